>>> src/u2da_pkg.sv
`timescale 1ns / 1ps

package u2da_pkg;

  // Ten BCD digits cover every 32-bit value.
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int NDIG_W     = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int IN_BITS    = 32;
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  // Queue between front and back.
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = 1;
  localparam int QCOUNT_W = 2;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd;
    logic [NDIG_W-1:0]                  ndig;
  } q_entry_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

endpackage

>>> src/unsigned_to_decimal_ascii_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                         Content
// in_       slave      in_tvalid in_tready in_tdata    one unsigned value per request
// out_      master     out_tvalid out_tready out_tdata one ASCII digit per request,
//                      out_tlast                       tlast on the final digit
//
// Flow: the front converts by shift-add-3, one bit per cycle; the back emits one
// digit per cycle while out_tready is high and overlaps with the next conversion
// through a two-entry queue.
// Reset: rst_n synchronous, active low; clears the front FSM, queue and output.
// Stalls: out_tready low holds the output register; the queue fills, then the
// front holds its finished result and in_tready stays low.

module unsigned_to_decimal_ascii_core import u2da_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic        out_tlast
);

  q_entry_t          push_data, pop_data;
  logic              push, q_full, pop, q_valid;
  logic [CHAR_W-1:0] digit;

  // Front: accept a value and run the binary-to-BCD conversion.
  u2da_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Queue: hold converted BCD words with their digit count.
  u2da_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .valid     (q_valid)
  );

  // Back: drop leading zeros and emit digits most significant first.
  u2da_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_digit (digit),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, digit};

endmodule

>>> src/u2da_front.sv
`timescale 1ns / 1ps

module u2da_front import u2da_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IN_BITS-1:0] in_value,
  output logic               push,
  output q_entry_t           push_data,
  input  logic               q_full
);

  localparam int USED  = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int CNT_W = $clog2(USED);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(USED - 1);

  fe_state_t        state_r, state_nxt;
  logic [USED-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BCD_W-1:0] bcd_adj;
  logic [NDIG_W-1:0] ndig;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_r[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_r[k*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_r[k*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Significant digit count; zero still gives one digit.
  always_comb begin
    ndig = NDIG_W'(1);
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_r[k*DIGIT_W +: DIGIT_W] != '0) begin
        ndig = NDIG_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    push_data.bcd  = bcd_r;
    push_data.ndig = ndig;
    unique case (state_r)
      FE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          bin_nxt   = in_value[USED-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = FE_CONV;
        end
      end
      FE_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[USED-1]};
        bin_nxt = {bin_r[USED-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full && !in_ready)
    else $error("front pushed into a full queue");
`endif

endmodule

>>> src/u2da_queue.sv
`timescale 1ns / 1ps

module u2da_queue import u2da_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     valid
);

  q_entry_t              mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]     wptr_r, rptr_r;
  logic [QCOUNT_W-1:0]   count_r;
  logic                  do_push, do_pop;

  assign full     = (count_r == QCOUNT_W'(Q_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + QPTR_W'(1);
      if (do_pop)  rptr_r <= rptr_r + QPTR_W'(1);
      if (do_push && !do_pop) count_r <= count_r + QCOUNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCOUNT_W'(1);
    end
    if (do_push) mem_r[wptr_r] <= push_data;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCOUNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

>>> src/u2da_back.sv
`timescale 1ns / 1ps

module u2da_back import u2da_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  q_entry_t          q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_digit,
  output logic              out_last
);

  q_entry_t          cur_r;
  logic              active_r;
  logic [NDIG_W-1:0] idx_r;
  logic              out_valid_r, out_last_r;
  logic [CHAR_W-1:0] out_digit_r;
  logic              load;
  logic [DIGIT_W-1:0] digit_sel;

  // Advance one digit whenever the output slot is free or drains now.
  assign load      = active_r && (!out_valid_r || out_ready);
  assign pop       = q_valid && (!active_r || (load && idx_r == '0));
  assign digit_sel = cur_r.bcd[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        active_r <= 1'b1;
        idx_r    <= q_data.ndig - NDIG_W'(1);
      end else if (load) begin
        if (idx_r == '0) active_r <= 1'b0;
        else idx_r <= idx_r - NDIG_W'(1);
      end
    end
    if (pop) cur_r <= q_data;
    if (load) begin
      out_digit_r <= ASCII_ZERO + CHAR_W'(digit_sel);
      out_last_r  <= (idx_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_digit = out_digit_r;
  assign out_last  = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (load && idx_r == '0) |=> out_last_r)
    else $error("final digit lost its last marker");
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_digit_r >= ASCII_ZERO) && (out_digit_r <= ASCII_NINE))
    else $error("digit character out of range");
`endif

endmodule

>>> sim/u2da_digit_checker.sv
`timescale 1ns / 1ps

// Watch both channels, work out the decimal digits of every accepted value and
// compare each accepted digit request with the oldest digit still owed.
module u2da_digit_checker import u2da_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [5:0] digit_char, [7:6] zero
  input  logic        out_tlast,
  output int          fail_count,
  output int          digits_pending
);

  localparam logic [63:0] VALUE_MASK = (VALUE_BITS >= 32) ? 64'hFFFF_FFFF :
                                       ((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [63:0] DEC_RADIX  = 64'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_t;

  digit_t owed_digits[$];
  int     mismatches = 0;

  always @(posedge clk) begin : track
    logic [63:0]        v;
    logic [DIGIT_W-1:0] rev [NUM_DIGITS];
    int                 n;
    digit_t             want;
    if (rst_n) begin
      // Retire the digit leaving the block first.
      if (out_tvalid && out_tready) begin
        if (owed_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: digit request with nothing owed: tdata %0d last %0b",
                     $realtime, out_tdata, out_tlast);
        end else begin
          want = owed_digits.pop_front();
          if (out_tdata !== {{(8-CHAR_W){1'b0}}, want.digit_char} ||
              out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: digit mismatch: expected char %0d last %0b, got %0d last %0b",
                       $realtime, want.digit_char, want.last, out_tdata, out_tlast);
          end
        end
      end
      // Split the accepted value into digits, least significant first, then owe
      // them most significant first.
      if (in_tvalid && in_tready) begin
        v = {32'd0, in_tdata} & VALUE_MASK;
        n = 0;
        do begin
          rev[n] = DIGIT_W'(v % DEC_RADIX);
          v      = v / DEC_RADIX;
          n++;
        end while (v != 64'd0 && n < NUM_DIGITS);
        for (int k = 0; k < n; k++)
          owed_digits.push_back('{digit_char: ASCII_ZERO + CHAR_W'(rev[n-1-k]),
                                  last:       (k == n - 1)});
      end
    end
    fail_count     <= mismatches;
    digits_pending <= owed_digits.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import u2da_pkg::*; ();

  localparam int VALUE_BITS   = 32;
  localparam int STALL_LIMIT  = 4000;  // cycles without any accepted request
  localparam int DRAIN_CYCLES = 60;    // front conversion plus digit emission
  localparam int RANDOM_ITEMS = 82;    // per idling phase

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = 32'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int fail_count;
  int digits_pending;
  int send_idle_pct = 22;
  int recv_idle_pct = 80;
  int quiet_cycles  = 0;

  always #4 clk = ~clk;

  unsigned_to_decimal_ascii_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  u2da_digit_checker #(
    .VALUE_BITS (VALUE_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .digits_pending (digits_pending)
  );

  // Stall the digit stream at the rate of the current phase.
  always @(posedge clk)
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // End the run when neither channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** unsigned_to_decimal_ascii_core: FAILED **");
      $finish;
    end
  end

  // Offer one value, idling first at the sender's rate, and hold it until taken.
  task automatic send_value(input logic [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the sender off until every owed digit has come out.
  task automatic drain_digits();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
  endtask

  // Mix full-range values, values next to powers of ten and values of a chosen
  // digit count, so that every length from one to ten digits shows up often.
  function automatic logic [31:0] pick_value();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] v;
    int          ndig;
    lo = 64'd1;
    case ($urandom_range(0, 3))
      0: v = {32'd0, $urandom()};
      1: begin
        repeat ($urandom_range(0, 9)) lo = lo * 64'd10;
        v = lo + $urandom_range(0, 2) - 64'd1;
      end
      default: begin
        ndig = $urandom_range(1, NUM_DIGITS);
        repeat (ndig - 1) lo = lo * 64'd10;
        hi = lo * 64'd10 - 64'd1;
        if (ndig == 1) lo = 64'd0;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        v = lo + ({$urandom(), $urandom()} % (hi - lo + 64'd1));
      end
    endcase
    return v[31:0];
  endfunction

  initial begin
    logic [31:0] directed [25];
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                 32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999,
                 32'd1000000, 32'd9999999, 32'd10000000, 32'd99999999,
                 32'd100000000, 32'd999999999, 32'd1000000000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes: zero, every digit count at both ends, full range, bit patterns.
    foreach (directed[i]) send_value(directed[i]);
    drain_digits();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 22; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        send_value(pick_value());
        if ($urandom_range(0, 29) == 0) drain_digits();
      end
      drain_digits();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && digits_pending == 0) begin
      $display("** unsigned_to_decimal_ascii_core: PASSED **");
    end else begin
      $display("** unsigned_to_decimal_ascii_core: FAILED **");
    end
    $finish;
  end

endmodule
